### rtl/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg: shared types and constants for the sphere pair contact pipeline
// Holds field widths and the side-band words carried through the square root
// and division pipelines.
// ----------------------------------------------------------------------------
package scp_pkg;

	localparam int POS_W   = 32;  // Q15.16 position
	localparam int RAD_W   = 30;  // Q14.16 radius
	localparam int SUM_W   = 31;  // radius sum / distance / depth
	localparam int OWN_W   = 16;
	localparam int NRM_W   = 18;  // Q1.16 normal
	localparam int SQ_W    = 62;  // squared distance when in contact
	localparam int QUO_W   = 18;  // doubled normal quotient
	localparam int NMAG_W  = 17;  // normal magnitude, up to 65536
	localparam int LANES   = 3;

	// side-band word beside the square root pipeline
	typedef struct packed {
		logic [LANES-1:0][POS_W-1:0] base;
		logic [RAD_W-1:0]            r2;
		logic [SUM_W-1:0]            sum;
		logic [LANES-1:0]            neg;
		logic [LANES-1:0][SUM_W-1:0] mag;
		logic [OWN_W-1:0]            own1;
		logic [OWN_W-1:0]            own2;
	} scp_sqrt_sb_t;

	// side-band word beside the division pipeline
	typedef struct packed {
		logic [LANES-1:0][POS_W-1:0] base;
		logic [RAD_W-1:0]            r2;
		logic [SUM_W-1:0]            depth;
		logic [LANES-1:0]            neg;
		logic                        dzero;
		logic [OWN_W-1:0]            own1;
		logic [OWN_W-1:0]            own2;
	} scp_div_sb_t;

endpackage

### rtl/scp_sqrt.sv
// ----------------------------------------------------------------------------
// scp_sqrt: pipelined integer square root
// One result bit per stage, floor(sqrt) of a 62-bit value over 31 stages,
// with a side-band word travelling beside the data.
// ----------------------------------------------------------------------------
module scp_sqrt import scp_pkg::*; #(
	parameter int SB_W = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  logic [SQ_W-1:0]      in_rad,
	input  logic [SB_W-1:0]      in_sb,
	output logic                 out_vld,
	output logic [SUM_W-1:0]     out_root,
	output logic [SB_W-1:0]      out_sb
);

	localparam int STEPS = SQ_W / 2;
	localparam int REM_W = SUM_W + 3;

	logic             vld_s  [0:STEPS];
	logic [REM_W-1:0] rem_s  [0:STEPS];
	logic [SUM_W-1:0] root_s [0:STEPS];
	logic [SQ_W-1:0]  rad_s  [0:STEPS];
	logic [SB_W-1:0]  sb_s   [0:STEPS];

	// stage zero is the incoming word
	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = in_rad;
	assign sb_s[0]   = in_sb;

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [REM_W-1:0] rem_sh;
		logic [REM_W-1:0] trial;
		logic             ge;

		// bring down two bits, try root*4+1
		assign rem_sh = {rem_s[k][REM_W-3:0], rad_s[k][SQ_W-1 -: 2]};
		assign trial  = {1'b0, root_s[k], 2'b01};
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
			root_s[k+1] <= {root_s[k][SUM_W-2:0], ge};
			rad_s[k+1]  <= {rad_s[k][SQ_W-3:0], 2'b00};
			sb_s[k+1]   <= sb_s[k];
		end
	end

	assign out_vld  = vld_s[STEPS];
	assign out_root = root_s[STEPS];
	assign out_sb   = sb_s[STEPS];

endmodule

### rtl/scp_div.sv
// ----------------------------------------------------------------------------
// scp_div: pipelined three-lane restoring divider
// Gives floor(m * 2^17 / d) for each lane, m <= d, one quotient bit a stage.
// ----------------------------------------------------------------------------
module scp_div import scp_pkg::*; #(
	parameter int SB_W = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_vld,
	input  logic [SUM_W-1:0]                 in_d,
	input  logic [LANES-1:0][SUM_W-1:0]      in_m,
	input  logic [SB_W-1:0]                  in_sb,
	output logic                             out_vld,
	output logic [LANES-1:0][QUO_W-1:0]      out_quo,
	output logic [SB_W-1:0]                  out_sb
);

	localparam int STEPS = QUO_W - 1;

	logic                         vld_s [0:STEPS];
	logic [SUM_W-1:0]             d_s   [0:STEPS];
	logic [LANES-1:0][SUM_W-1:0]  rem_s [0:STEPS];
	logic [LANES-1:0][QUO_W-1:0]  quo_s [0:STEPS];
	logic [SB_W-1:0]              sb_s  [0:STEPS];

	// first stage: leading quotient bit (m may equal d)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		d_s[0]  <= in_d;
		sb_s[0] <= in_sb;
		for (int i = 0; i < LANES; i++) begin
			if (in_m[i] >= in_d) begin
				rem_s[0][i] <= in_m[i] - in_d;
				quo_s[0][i] <= QUO_W'(1);
			end else begin
				rem_s[0][i] <= in_m[i];
				quo_s[0][i] <= '0;
			end
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			logic [SUM_W:0] sh;
			d_s[k+1]  <= d_s[k];
			sb_s[k+1] <= sb_s[k];
			for (int i = 0; i < LANES; i++) begin
				sh = {rem_s[k][i], 1'b0};
				if (sh >= {1'b0, d_s[k]}) begin
					rem_s[k+1][i] <= SUM_W'(sh - {1'b0, d_s[k]});
					quo_s[k+1][i] <= {quo_s[k][i][QUO_W-2:0], 1'b1};
				end else begin
					rem_s[k+1][i] <= sh[SUM_W-1:0];
					quo_s[k+1][i] <= {quo_s[k][i][QUO_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_vld = vld_s[STEPS];
	assign out_quo = quo_s[STEPS];
	assign out_sb  = sb_s[STEPS];

endmodule

### rtl/sphere_pair_contact.sv
// ----------------------------------------------------------------------------
// sphere_pair_contact: narrow-phase sphere against sphere contact generator
// Takes one candidate pair every clock (busy is never raised) and pulses
// strobe with the contact for pairs that touch; pairs that do not touch
// leave no word. Most of the pipeline depth lies in the bit-per-stage
// square root (31 stages) and the normal divider (18 stages).
// The receiver cannot stall: each result is on the ports for one cycle only.
// ----------------------------------------------------------------------------
module sphere_pair_contact import scp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [POS_W-1:0] first_x,
	input  logic signed [POS_W-1:0] first_y,
	input  logic signed [POS_W-1:0] first_z,
	input  logic [RAD_W-1:0]        first_radius,
	input  logic signed [POS_W-1:0] second_x,
	input  logic signed [POS_W-1:0] second_y,
	input  logic signed [POS_W-1:0] second_z,
	input  logic [RAD_W-1:0]        second_radius,
	input  logic [OWN_W-1:0]        first_owner,
	input  logic [OWN_W-1:0]        second_owner,
	output logic                    strobe,
	output logic signed [NRM_W-1:0] normal_x,
	output logic signed [NRM_W-1:0] normal_y,
	output logic signed [NRM_W-1:0] normal_z,
	output logic [SUM_W-1:0]        depth,
	output logic signed [POS_W-1:0] contact_x,
	output logic signed [POS_W-1:0] contact_y,
	output logic signed [POS_W-1:0] contact_z,
	output logic [OWN_W-1:0]        body_one,
	output logic [OWN_W-1:0]        body_two
);

	localparam int DV_W  = POS_W + 1;
	localparam int PRD_W = RAD_W + NMAG_W;
	localparam int CS_W  = POS_W + 2;

	assign busy = 1'b0;

	// stage 1: centre differences and radius sum
	logic                       vld_s1;
	logic [LANES-1:0][DV_W-1:0] dv_s1;
	logic [SUM_W-1:0]           sum_s1;
	logic [LANES-1:0][POS_W-1:0] base_s1;
	logic [RAD_W-1:0]           r2_s1;
	logic [OWN_W-1:0]           own1_s1, own2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		dv_s1[0] <= DV_W'($signed(first_x)) - DV_W'($signed(second_x));
		dv_s1[1] <= DV_W'($signed(first_y)) - DV_W'($signed(second_y));
		dv_s1[2] <= DV_W'($signed(first_z)) - DV_W'($signed(second_z));
		sum_s1   <= SUM_W'(first_radius) + SUM_W'(second_radius);
		base_s1  <= {second_z, second_y, second_x};
		r2_s1    <= second_radius;
		own1_s1  <= first_owner;
		own2_s1  <= second_owner;
	end

	// stage 2: magnitudes and per-axis reject
	logic                        vld_s2, far_s2;
	logic [LANES-1:0]            neg_s2;
	logic [LANES-1:0][SUM_W-1:0] mag_s2;
	logic [SUM_W-1:0]            sum_s2;
	logic [LANES-1:0][POS_W-1:0] base_s2;
	logic [RAD_W-1:0]            r2_s2;
	logic [OWN_W-1:0]            own1_s2, own2_s2;
	logic [LANES-1:0][DV_W-1:0]  magw;
	logic                        far_c;

	always_comb begin
		far_c = 1'b0;
		for (int i = 0; i < LANES; i++) begin
			magw[i] = dv_s1[i][DV_W-1] ? (DV_W'(0) - dv_s1[i]) : dv_s1[i];
			if (magw[i] > DV_W'(sum_s1))
				far_c = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		far_s2  <= far_c;
		for (int i = 0; i < LANES; i++) begin
			neg_s2[i] <= dv_s1[i][DV_W-1];
			mag_s2[i] <= magw[i][SUM_W-1:0];
		end
		sum_s2  <= sum_s1;
		base_s2 <= base_s1;
		r2_s2   <= r2_s1;
		own1_s2 <= own1_s1;
		own2_s2 <= own2_s1;
	end

	// stage 3: squares
	logic                       vld_s3;
	logic [LANES-1:0][SQ_W-1:0] sq_s3;
	logic [SQ_W-1:0]            ss_s3;
	scp_sqrt_sb_t               sb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2 & ~far_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++)
			sq_s3[i] <= SQ_W'(mag_s2[i]) * SQ_W'(mag_s2[i]);
		ss_s3     <= SQ_W'(sum_s2) * SQ_W'(sum_s2);
		sb_s3.base <= base_s2;
		sb_s3.r2   <= r2_s2;
		sb_s3.sum  <= sum_s2;
		sb_s3.neg  <= neg_s2;
		sb_s3.mag  <= mag_s2;
		sb_s3.own1 <= own1_s2;
		sb_s3.own2 <= own2_s2;
	end

	// stage 4: squared distance and exact contact test
	logic               vld_s4;
	logic [SQ_W-1:0]    q_s4;
	scp_sqrt_sb_t       sb_s4;
	logic [SQ_W+1:0]    qsum;

	assign qsum = (SQ_W+2)'(sq_s3[0]) + (SQ_W+2)'(sq_s3[1]) + (SQ_W+2)'(sq_s3[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3 && (qsum <= (SQ_W+2)'(ss_s3));
		end
	end

	always_ff @(posedge clk) begin
		q_s4  <= qsum[SQ_W-1:0];
		sb_s4 <= sb_s3;
	end

	// distance
	logic          sq_vld;
	logic [SUM_W-1:0] cen_dist;
	scp_sqrt_sb_t  sq_sb;

	scp_sqrt #(.SB_W($bits(scp_sqrt_sb_t))) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s4),
		.in_rad   (q_s4),
		.in_sb    (sb_s4),
		.out_vld  (sq_vld),
		.out_root (cen_dist),
		.out_sb   (sq_sb)
	);

	// normal quotients
	scp_div_sb_t dv_sb_in, dv_sb;
	logic        dv_vld;
	logic [LANES-1:0][QUO_W-1:0] quo;

	always_comb begin
		dv_sb_in.base  = sq_sb.base;
		dv_sb_in.r2    = sq_sb.r2;
		dv_sb_in.depth = sq_sb.sum - cen_dist;
		dv_sb_in.neg   = sq_sb.neg;
		dv_sb_in.dzero = (cen_dist == '0);
		dv_sb_in.own1  = sq_sb.own1;
		dv_sb_in.own2  = sq_sb.own2;
	end

	scp_div #(.SB_W($bits(scp_div_sb_t))) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (sq_vld),
		.in_d    (cen_dist),
		.in_m    (sq_sb.mag),
		.in_sb   (dv_sb_in),
		.out_vld (dv_vld),
		.out_quo (quo),
		.out_sb  (dv_sb)
	);

	// stage 5: round the normal to nearest
	logic                         vld_s5;
	logic [LANES-1:0][NMAG_W-1:0] nmag_s5;
	scp_div_sb_t                  sb_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		logic [QUO_W:0] rnd;
		for (int i = 0; i < LANES; i++) begin
			rnd = (QUO_W+1)'(quo[i]) + (QUO_W+1)'(1);
			nmag_s5[i] <= dv_sb.dzero ? '0 : rnd[NMAG_W:1];
		end
		sb_s5 <= dv_sb;
	end

	// stage 6: radius times normal
	logic                         vld_s6;
	logic [LANES-1:0][PRD_W-1:0]  prd_s6;
	logic [LANES-1:0][NRM_W-1:0]  nrm_s6;
	scp_div_sb_t                  sb_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++) begin
			prd_s6[i] <= PRD_W'(sb_s5.r2) * PRD_W'(nmag_s5[i]);
			nrm_s6[i] <= sb_s5.neg[i] ? (NRM_W'(0) - NRM_W'(nmag_s5[i]))
			                          : NRM_W'(nmag_s5[i]);
		end
		sb_s6 <= sb_s5;
	end

	// stage 7: rounded offset, add to the second centre, saturate
	logic [LANES-1:0][POS_W-1:0] cpt;

	always_comb begin
		logic [PRD_W:0]   pr;
		logic [CS_W-1:0]  off;
		logic [CS_W-1:0]  c;
		for (int i = 0; i < LANES; i++) begin
			pr  = (PRD_W+1)'(prd_s6[i]) + (PRD_W+1)'(32768);
			off = CS_W'(pr[PRD_W:16]);
			if (sb_s6.neg[i])
				off = CS_W'(0) - off;
			c = CS_W'($signed(sb_s6.base[i])) + off;
			if (!c[CS_W-1] && (c[CS_W-2:POS_W-1] != '0))
				cpt[i] = {1'b0, {(POS_W-1){1'b1}}};
			else if (c[CS_W-1] && (c[CS_W-2:POS_W-1] != '1))
				cpt[i] = {1'b1, {(POS_W-1){1'b0}}};
			else
				cpt[i] = c[POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		normal_x  <= nrm_s6[0];
		normal_y  <= nrm_s6[1];
		normal_z  <= nrm_s6[2];
		depth     <= sb_s6.depth;
		contact_x <= cpt[0];
		contact_y <= cpt[1];
		contact_z <= cpt[2];
		body_one  <= sb_s6.own1;
		body_two  <= sb_s6.own2;
	end

endmodule

### test/sphere_pair_contact_tb.sv
// ----------------------------------------------------------------------------
// sphere_pair_contact_tb: self-checking bench for the sphere contact block
// Feeds candidate sphere pairs through start/busy with random idle bursts,
// predicts each contact word in fixed point and compares the strobed words
// field by field, in order, against the expected ones.
// ----------------------------------------------------------------------------
module sphere_pair_contact_tb;
	import scp_pkg::*;

	localparam int LATENCY   = 56;
	localparam int MAX_CYCLE = 400000;

	typedef struct {
		logic signed [POS_W-1:0] ax, ay, az, bx, by, bz;
		logic [RAD_W-1:0]        ra, rb;
		logic [OWN_W-1:0]        oa, ob;
	} pair_t;

	typedef struct {
		logic signed [NRM_W-1:0] nx, ny, nz;
		logic [SUM_W-1:0]        dep;
		logic signed [POS_W-1:0] cx, cy, cz;
		logic [OWN_W-1:0]        b1, b2;
	} contact_t;

	logic clk, arst_n, start, busy, strobe;
	logic signed [POS_W-1:0] first_x, first_y, first_z, second_x, second_y, second_z;
	logic [RAD_W-1:0]        first_radius, second_radius;
	logic [OWN_W-1:0]        first_owner, second_owner;
	logic signed [NRM_W-1:0] normal_x, normal_y, normal_z;
	logic [SUM_W-1:0]        depth;
	logic signed [POS_W-1:0] contact_x, contact_y, contact_z;
	logic [OWN_W-1:0]        body_one, body_two;

	pair_t    pending_pairs[$];
	contact_t expected_contacts[$];
	int       mismatches, contacts_seen, pairs_sent, cycle;
	int       idle_left;
	bit       idling_on = 1'b1;

	sphere_pair_contact u_top (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// integer square root, floor
	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > v)
			bit_v >>= 2;
		while (bit_v != 0) begin
			if (v >= res + bit_v) begin
				v -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		return res;
	endfunction

	// contact prediction for one pair; returns 0 when the spheres do not touch
	function automatic bit predict_contact(pair_t p, output contact_t c);
		longint          a[3], b[3], dv[3], nv[3], cv[3], off;
		longint unsigned s, q, d, m, num, pq;
		a = '{p.ax, p.ay, p.az};
		b = '{p.bx, p.by, p.bz};
		s = p.ra + p.rb;
		q = 0;
		for (int i = 0; i < 3; i++) begin
			dv[i] = a[i] - b[i];
			m = dv[i] < 0 ? -dv[i] : dv[i];
			if (m > s)
				return 0;
		end
		for (int i = 0; i < 3; i++) begin
			m = dv[i] < 0 ? -dv[i] : dv[i];
			q += m * m;
		end
		if (q > s * s)
			return 0;
		d = root_floor(q);
		for (int i = 0; i < 3; i++) begin
			if (d == 0) begin
				nv[i] = 0;
			end else begin
				num = (dv[i] < 0 ? -dv[i] : dv[i]) << 16;
				pq = (2 * num + d) / (2 * d);
				nv[i] = dv[i] < 0 ? -longint'(pq) : longint'(pq);
			end
			pq = (longint'(p.rb) * (nv[i] < 0 ? -nv[i] : nv[i]) + 32768) >> 16;
			off = nv[i] < 0 ? -longint'(pq) : longint'(pq);
			cv[i] = b[i] + off;
			if (cv[i] > 64'sd2147483647) cv[i] = 64'sd2147483647;
			if (cv[i] < -64'sd2147483648) cv[i] = -64'sd2147483648;
		end
		c.nx = NRM_W'(nv[0]); c.ny = NRM_W'(nv[1]); c.nz = NRM_W'(nv[2]);
		c.dep = SUM_W'(s - d);
		c.cx = POS_W'(cv[0]); c.cy = POS_W'(cv[1]); c.cz = POS_W'(cv[2]);
		c.b1 = p.oa; c.b2 = p.ob;
		return 1;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		mismatches++;
		$display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle);
	endtask

	// append a pair to the stimulus queue
	task automatic queue_pair(pair_t p);
		pending_pairs.insert(pending_pairs.size(), p);
	endtask

	function automatic pair_t make_pair(logic signed [POS_W-1:0] ax, ay, az, bx, by, bz,
			logic [RAD_W-1:0] ra, rb);
		pair_t p;
		p.ax = ax; p.ay = ay; p.az = az; p.bx = bx; p.by = by; p.bz = bz;
		p.ra = ra; p.rb = rb;
		p.oa = $urandom; p.ob = $urandom;
		return p;
	endfunction

	// random pair: mostly near each other so that contacts are common
	function automatic pair_t random_pair();
		pair_t p;
		int    mode, span;
		mode = $urandom_range(0, 9);
		p.oa = $urandom; p.ob = $urandom;
		p.ra = $urandom; p.rb = $urandom;
		p.bx = $urandom; p.by = $urandom; p.bz = $urandom;
		if (mode < 7) begin
			span = 1 << $urandom_range(4, 30);
			p.ra = $urandom_range(0, span - 1);
			p.rb = $urandom_range(0, span - 1);
			if (mode == 0) p.rb = RAD_W'('1) - $urandom_range(0, 3);
			p.ax = p.bx + $signed($urandom_range(0, 2 * span)) - span;
			p.ay = p.by + $signed($urandom_range(0, 2 * span)) - span;
			p.az = p.bz + $signed($urandom_range(0, 2 * span)) - span;
			if (mode == 1) p.ax = p.bx;
		end else begin
			p.ax = $urandom; p.ay = $urandom; p.az = $urandom;
		end
		return p;
	endfunction

	// stimulus
	initial begin
		logic signed [POS_W-1:0] mx, mn;
		logic [RAD_W-1:0]        rm;
		pair_t                   p;
		mx = 32'sh7fffffff; mn = 32'sh80000000; rm = '1;
		// coincident centres, zero radii, extremes, touching and far apart
		queue_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
		queue_pair(make_pair(5, -7, 9, 5, -7, 9, 100, 3));
		queue_pair(make_pair(mx, mx, mx, mx, mx, mx, rm, rm));
		queue_pair(make_pair(mn, mn, mn, mn, mn, mn, rm, rm));
		queue_pair(make_pair(mx, 0, 0, mx - 100, 0, 0, 60, 40));
		queue_pair(make_pair(mx, 0, 0, mx - 101, 0, 0, 60, 40));
		queue_pair(make_pair(mn, 0, 0, mn + 100, 0, 0, 60, 40));
		queue_pair(make_pair(0, 3, 0, 0, 0, 4, 3, 2));
		queue_pair(make_pair(0, 3, 0, 0, 0, 4, 2, 2));
		queue_pair(make_pair(mx - rm, 0, 0, mx, 0, 0, rm, rm));
		queue_pair(make_pair(mn + rm, 0, 0, mn, 0, 0, rm, rm));
		queue_pair(make_pair(mx, mn, mx, mx - 1000, mn + 1000, mx - 1000, rm, rm));
		queue_pair(make_pair(mx, mx, mx, mn, mn, mn, rm, rm));
		queue_pair(make_pair(1, 1, 1, 0, 0, 0, 1, 1));
		queue_pair(make_pair(-1, 0, 0, 0, 0, 0, 0, 1));
		p = make_pair(0, 0, 0, 0, 0, 0, 0, 0);
		p.oa = '1; p.ob = '0;
		queue_pair(p);
		p.oa = '0; p.ob = '1;
		queue_pair(p);
		for (int i = 0; i < 1850; i++)
			queue_pair(random_pair());
	end

	// driver: takes the next pair when free, with random idle bursts early on
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			idle_left <= 0;
			{first_x, first_y, first_z, second_x, second_y, second_z} <= '0;
			{first_radius, second_radius, first_owner, second_owner} <= '0;
		end else begin
			contact_t c;
			if (start && !busy) begin
				pairs_sent++;
				if (predict_contact(pending_pairs[0], c))
					expected_contacts.insert(expected_contacts.size(), c);
				void'(pending_pairs.pop_front());
			end
			if (start && busy) begin
				// hold the current word
			end else if (idle_left > 0) begin
				start <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (idling_on && pending_pairs.size() > 300 &&
					$urandom_range(0, 9) == 0) begin
				start <= 1'b0;
				idle_left <= $urandom_range(0, 10);
			end else if (pending_pairs.size() > 0) begin
				start <= 1'b1;
				first_x <= pending_pairs[0].ax; first_y <= pending_pairs[0].ay;
				first_z <= pending_pairs[0].az; first_radius <= pending_pairs[0].ra;
				second_x <= pending_pairs[0].bx; second_y <= pending_pairs[0].by;
				second_z <= pending_pairs[0].bz; second_radius <= pending_pairs[0].rb;
				first_owner <= pending_pairs[0].oa; second_owner <= pending_pairs[0].ob;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// toggle idling in stretches so some phases run back to back
	always @(posedge clk)
		if ($urandom_range(0, 199) == 0)
			idling_on <= ~idling_on;

	// monitor: compare each strobed word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			contact_t w;
			contacts_seen++;
			if (expected_contacts.size() == 0) begin
				mismatches++;
				$display("MISMATCH unexpected contact word at cycle %0d", cycle);
			end else begin
				w = expected_contacts.pop_front();
				if (normal_x !== w.nx) report_mismatch("normal_x", normal_x, w.nx);
				if (normal_y !== w.ny) report_mismatch("normal_y", normal_y, w.ny);
				if (normal_z !== w.nz) report_mismatch("normal_z", normal_z, w.nz);
				if (depth !== w.dep) report_mismatch("depth", depth, w.dep);
				if (contact_x !== w.cx) report_mismatch("contact_x", contact_x, w.cx);
				if (contact_y !== w.cy) report_mismatch("contact_y", contact_y, w.cy);
				if (contact_z !== w.cz) report_mismatch("contact_z", contact_z, w.cz);
				if (body_one !== w.b1) report_mismatch("body_one", body_one, w.b1);
				if (body_two !== w.b2) report_mismatch("body_two", body_two, w.b2);
			end
		end
	end

	// reset, completion and timeout
	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		while ((pending_pairs.size() > 0 || start || expected_contacts.size() > 0)
				&& cycle < MAX_CYCLE) begin
			@(posedge clk);
			cycle++;
		end
		if (cycle >= MAX_CYCLE) begin
			$display("timeout with %0d words outstanding", expected_contacts.size());
			$display("sphere_pair_contact test failed");
		end else begin
			repeat (LATENCY + 10) @(posedge clk);
			if (expected_contacts.size() > 0)
				mismatches++;
			$display("%0d pairs sent, %0d contact words checked, %0d mismatches",
				pairs_sent, contacts_seen, mismatches);
			if (mismatches == 0)
				$display("sphere_pair_contact test passed");
			else
				$display("sphere_pair_contact test failed");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/scp_pkg.sv
rtl/scp_sqrt.sv
rtl/scp_div.sv
rtl/sphere_pair_contact.sv
test/sphere_pair_contact_tb.sv
